[design/dpb_pkg.sv]
`default_nettype none

package dpb_pkg;

	localparam int MAX_DIMENSION_DEF = 4096;
	localparam int MAX_STRIDE_DEF    = 16;

	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int STRIDE_W  = 5;
	localparam int CENTER_W  = 20;
	localparam int INV_W     = 24;
	localparam int DEPTH_W   = 32;
	localparam int COORD_W   = 32;

	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		REG_DEPTH_ENCODING,
		REG_PIXEL_STRIDE,
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_INV_FOCAL_X,
		REG_INV_FOCAL_Y,
		REG_RANGE_LO,
		REG_RANGE_MAX
	} reg_idx_t;

	typedef struct packed {
		logic                depth_encoding;
		logic [STRIDE_W-1:0] pixel_stride;
		logic [DEPTH_W-1:0]  range_lo;
		logic [DEPTH_W-1:0]  range_max;
	} front_cfg_t;

	typedef struct packed {
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [INV_W-1:0]    inv_focal_x;
		logic [INV_W-1:0]    inv_focal_y;
	} back_cfg_t;

endpackage

`default_nettype wire

[design/dpb_front.sv]
`default_nettype none

module dpb_front #(
	parameter int MAX_DIMENSION = dpb_pkg::MAX_DIMENSION_DEF,
	parameter int MAX_STRIDE    = dpb_pkg::MAX_STRIDE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dpb_pkg::front_cfg_t              cfg,
	input  logic                             pixel_valid,
	output logic                             pixel_stall,
	input  logic [dpb_pkg::DEPTH_W-1:0]      depth_word,
	input  logic                             frame_first,
	input  logic                             row_last,
	input  logic [dpb_pkg::QCNT_W-1:0]       q_count,
	output logic                             push,
	output logic [$clog2(MAX_DIMENSION)-1:0] push_col,
	output logic [$clog2(MAX_DIMENSION)-1:0] push_row,
	output logic [dpb_pkg::DEPTH_W-1:0]      push_z
);
	import dpb_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIMENSION);
	localparam int PH_W  = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
	localparam int EW    = PH_W + 6;
	localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_DIMENSION - 1);
	localparam logic [EW-1:0]    STRIDE_MAX = EW'(MAX_STRIDE);

	localparam logic        ENC_FLOAT = 1'b1;
	localparam logic [30:0] MM_RECIP  = 31'd1099511628;
	localparam logic [28:0] MM_BIAS   = 29'd62;
	localparam logic [7:0]  EXP_UNITY = 8'd134;
	localparam logic [7:0]  EXP_LIMIT = 8'd143;
	localparam logic [7:0]  EXP_SPEC  = 8'hFF;

	logic [CNT_W-1:0] col_q, row_q;
	logic [PH_W-1:0]  cph_q, rph_q;
	logic             v_s1;
	logic [CNT_W-1:0] col_s1, row_s1;
	logic [DEPTH_W-1:0] z_s1;

	logic             accept;
	logic [CNT_W-1:0] cur_col, cur_row;
	logic [PH_W-1:0]  cur_cph, cur_rph;
	logic             cand;
	logic [EW-1:0]    stride_ext, eff_stride;

	logic [15:0]        mm;
	logic [28:0]        mm_num;
	logic [59:0]        mm_prod;
	logic [7:0]         ex;
	logic [23:0]        man;
	logic [7:0]         sh;
	logic [24:0]        rnd;
	logic [DEPTH_W-1:0] dec_z;
	logic               dec_ok;

	function automatic logic [PH_W-1:0] next_ph(input logic [PH_W-1:0] p,
			input logic [EW-1:0] s);
		logic [EW-1:0] n;
		n = EW'(p) + EW'(1);
		return (n >= s) ? '0 : n[PH_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] next_cnt(input logic [CNT_W-1:0] c);
		return (c >= CNT_MAX) ? CNT_MAX : c + 1'b1;
	endfunction

	assign accept = pixel_valid && !pixel_stall;
	assign pixel_stall = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(v_s1))
		>= (QCNT_W + 1)'(QUEUE_DEPTH);

	always_comb begin
		cur_col = frame_first ? '0 : col_q;
		cur_row = frame_first ? '0 : row_q;
		cur_cph = frame_first ? '0 : cph_q;
		cur_rph = frame_first ? '0 : rph_q;
		cand    = (cur_cph == '0) && (cur_rph == '0);
		stride_ext = EW'(cfg.pixel_stride);
		if (stride_ext == '0) begin
			eff_stride = EW'(1);
		end else if (stride_ext > STRIDE_MAX) begin
			eff_stride = STRIDE_MAX;
		end else begin
			eff_stride = stride_ext;
		end
	end

	// millimeters: round(mm * 65536 / 1000) == floor((mm * 8192 + 62) / 125)
	always_comb begin
		mm      = depth_word[15:0];
		mm_num  = {mm, 13'd0} + MM_BIAS;
		mm_prod = 60'(mm_num) * 60'(MM_RECIP);
		ex      = depth_word[30:23];
		man     = {1'b1, depth_word[22:0]};
		sh      = '0;
		rnd     = '0;
		dec_z   = '0;
		dec_ok  = 1'b0;
		if (cfg.depth_encoding != ENC_FLOAT) begin
			dec_z  = DEPTH_W'(mm_prod[59:37]);
			dec_ok = (mm != '0);
		end else if (!depth_word[31] && ex != EXP_SPEC && ex != '0 && ex < EXP_LIMIT) begin
			if (ex >= EXP_UNITY) begin
				sh     = ex - EXP_UNITY;
				dec_z  = DEPTH_W'(man) << sh[3:0];
				dec_ok = 1'b1;
			end else begin
				sh = EXP_UNITY - ex;
				if (sh < 8'd25) begin
					rnd    = {1'b0, man} + (25'd1 << (sh[4:0] - 5'd1));
					dec_z  = DEPTH_W'(rnd >> sh[4:0]);
					dec_ok = (dec_z != '0);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cph_q <= '0;
			rph_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= accept && cand && dec_ok;
			if (accept) begin
				if (row_last) begin
					col_q <= '0;
					cph_q <= '0;
					row_q <= next_cnt(cur_row);
					rph_q <= next_ph(cur_rph, eff_stride);
				end else begin
					col_q <= next_cnt(cur_col);
					cph_q <= next_ph(cur_cph, eff_stride);
					row_q <= cur_row;
					rph_q <= cur_rph;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= cur_col;
			row_s1 <= cur_row;
			z_s1   <= dec_z;
		end
	end

	assign push     = v_s1 && (z_s1 >= cfg.range_lo) && (z_s1 <= cfg.range_max);
	assign push_col = col_s1;
	assign push_row = row_s1;
	assign push_z   = z_s1;

endmodule

`default_nettype wire

[design/dpb_queue.sv]
`default_nettype none

module dpb_queue #(
	parameter int DATA_W = 56
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [DATA_W-1:0]          push_data,
	input  logic                       pop,
	output logic                       head_valid,
	output logic [DATA_W-1:0]          head_data,
	output logic [dpb_pkg::QCNT_W-1:0] count
);
	import dpb_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic [DATA_W-1:0] entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_valid = (count_q != '0);
	assign head_data  = entries_q[rd_ptr_q];
	assign count      = count_q;

endmodule

`default_nettype wire

[design/dpb_lane.sv]
`default_nettype none

module dpb_lane #(
	parameter int POS_W = 12
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [POS_W-1:0]                 pos,
	input  logic [dpb_pkg::CENTER_W-1:0]     center,
	input  logic [dpb_pkg::INV_W-1:0]        inv,
	input  logic [dpb_pkg::DEPTH_W-1:0]      z,
	output logic signed [dpb_pkg::COORD_W-1:0] coord
);
	import dpb_pkg::*;

	localparam int PW = POS_W + 8;
	localparam int AW = (PW > CENTER_W) ? PW : CENTER_W;
	localparam int DW = AW + 1;
	localparam int MW = AW + DEPTH_W;
	localparam int RW = MW - 7;
	localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;
	localparam logic [RW-1:0] NEG_LIMIT = RW'(64'h0000_0000_8000_0000);
	localparam logic [RW-1:0] POS_LIMIT = RW'(64'h0000_0000_7FFF_FFFF);

	logic signed [DW-1:0] d;
	logic                 neg;
	logic [AW-1:0]        ad;
	logic [MW+24:0]       sum;
	logic [31:0]          lim;

	logic               neg_s1, neg_s2, neg_s3, neg_s4;
	logic [AW-1:0]      ad_s1;
	logic [DEPTH_W-1:0] z_s1;
	logic [MW-1:0]      mag_s2;
	logic [MW-1:0]      a_s3;
	logic [47:0]        b_s3;
	logic [RW-1:0]      r_s4;
	logic signed [COORD_W-1:0] coord_s5;

	always_comb begin
		d   = signed'(DW'({pos, 8'd0})) - signed'(DW'(center));
		neg = d[DW-1];
		ad  = neg ? AW'(-d) : AW'(d);
		// (mag * inv + 2^31) >> 32 with mag split at bit 24
		sum = {1'b0, a_s3, 24'd0} + (MW + 25)'(b_s3) + (MW + 25)'(ROUND_HALF);
		if (neg_s4) begin
			lim = (r_s4 > NEG_LIMIT) ? 32'h8000_0000 : r_s4[31:0];
		end else begin
			lim = (r_s4 > POS_LIMIT) ? 32'h7FFF_FFFF : r_s4[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1   <= neg;
			ad_s1    <= ad;
			z_s1     <= z;
			neg_s2   <= neg_s1;
			mag_s2   <= MW'(ad_s1) * MW'(z_s1);
			neg_s3   <= neg_s2;
			a_s3     <= MW'(mag_s2[MW-1:24]) * MW'(inv);
			b_s3     <= 48'(mag_s2[23:0]) * 48'(inv);
			neg_s4   <= neg_s3;
			r_s4     <= sum[MW+24:32];
			coord_s5 <= signed'(neg_s4 ? (32'd0 - lim) : lim);
		end
	end

	assign coord = coord_s5;

endmodule

`default_nettype wire

[design/dpb_back.sv]
`default_nettype none

module dpb_back #(
	parameter int MAX_DIMENSION = dpb_pkg::MAX_DIMENSION_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  dpb_pkg::back_cfg_t                 cfg,
	input  logic                               head_valid,
	input  logic [$clog2(MAX_DIMENSION)-1:0]   head_col,
	input  logic [$clog2(MAX_DIMENSION)-1:0]   head_row,
	input  logic [dpb_pkg::DEPTH_W-1:0]        head_z,
	output logic                               pop,
	output logic                               point_valid,
	input  logic                               point_stall,
	output logic signed [dpb_pkg::COORD_W-1:0] point_x,
	output logic signed [dpb_pkg::COORD_W-1:0] point_y,
	output logic [dpb_pkg::DEPTH_W-1:0]        point_z
);
	import dpb_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIMENSION);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [DEPTH_W-1:0] z_s1, z_s2, z_s3, z_s4, z_s5;

	assign en  = !v_s5 || !point_stall;
	assign pop = en && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= head_z;
			z_s2 <= z_s1;
			z_s3 <= z_s2;
			z_s4 <= z_s3;
			z_s5 <= z_s4;
		end
	end

	dpb_lane #(.POS_W(CNT_W)) u_lane_x (
		.clk    (clk),
		.en     (en),
		.pos    (head_col),
		.center (cfg.center_x),
		.inv    (cfg.inv_focal_x),
		.z      (head_z),
		.coord  (point_x)
	);

	dpb_lane #(.POS_W(CNT_W)) u_lane_y (
		.clk    (clk),
		.en     (en),
		.pos    (head_row),
		.center (cfg.center_y),
		.inv    (cfg.inv_focal_y),
		.z      (head_z),
		.coord  (point_y)
	);

	assign point_valid = v_s5;
	assign point_z     = z_s5;

endmodule

`default_nettype wire

[design/depth_pixel_backprojection.sv]
`default_nettype none

// Back-projects a raster stream of depth pixels to camera-frame points. One pixel
// transaction can be taken every clock while pixel_stall is low; a kept pixel
// passes the front stage (stride counters, depth decode and range test), the
// four-entry queue and the projection pipeline, whose two multiplier stages form
// |u - cx| * z and then the split product with the inverse focal length. Dropped
// pixels yield no point. pixel_stall rises only when the queue and the front stage
// together hold four points, which happens only while point_stall holds the
// output. Registers sit at byte address 4*i, are written with psel, penable and
// pwrite high, and should be changed only while no pixel is in flight.
module depth_pixel_backprojection #(
	parameter int MAX_DIMENSION = dpb_pkg::MAX_DIMENSION_DEF,
	parameter int MAX_STRIDE    = dpb_pkg::MAX_STRIDE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dpb_pkg::ADDR_W-1:0]         paddr,
	input  logic [dpb_pkg::DATA_W-1:0]         pwdata,
	output logic [dpb_pkg::DATA_W-1:0]         prdata,
	output logic                               pready,
	input  logic                               pixel_valid,
	output logic                               pixel_stall,
	input  logic [dpb_pkg::DEPTH_W-1:0]        depth_word,
	input  logic                               frame_first,
	input  logic                               row_last,
	output logic                               point_valid,
	input  logic                               point_stall,
	output logic signed [dpb_pkg::COORD_W-1:0] point_x,
	output logic signed [dpb_pkg::COORD_W-1:0] point_y,
	output logic [dpb_pkg::DEPTH_W-1:0]        point_z
);
	import dpb_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIMENSION);
	localparam int QD_W  = 2 * CNT_W + DEPTH_W;

	logic                depth_encoding_q;
	logic [STRIDE_W-1:0] pixel_stride_q;
	logic [CENTER_W-1:0] center_x_q, center_y_q;
	logic [INV_W-1:0]    inv_focal_x_q, inv_focal_y_q;
	logic [DEPTH_W-1:0]  range_lo_q, range_max_q;

	reg_idx_t   reg_idx;
	logic       cfg_wr;
	front_cfg_t fcfg;
	back_cfg_t  bcfg;

	logic               push, pop, head_valid;
	logic [CNT_W-1:0]   push_col, push_row;
	logic [DEPTH_W-1:0] push_z;
	logic [QD_W-1:0]    push_data, head_data;
	logic [QCNT_W-1:0]  q_count;

	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_encoding_q <= 1'b0;
			pixel_stride_q   <= STRIDE_W'(1);
			center_x_q       <= '0;
			center_y_q       <= '0;
			inv_focal_x_q    <= '0;
			inv_focal_y_q    <= '0;
			range_lo_q       <= '0;
			range_max_q      <= '1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_DEPTH_ENCODING: depth_encoding_q <= pwdata[0];
				REG_PIXEL_STRIDE:   pixel_stride_q   <= pwdata[STRIDE_W-1:0];
				REG_CENTER_X:       center_x_q       <= pwdata[CENTER_W-1:0];
				REG_CENTER_Y:       center_y_q       <= pwdata[CENTER_W-1:0];
				REG_INV_FOCAL_X:    inv_focal_x_q    <= pwdata[INV_W-1:0];
				REG_INV_FOCAL_Y:    inv_focal_y_q    <= pwdata[INV_W-1:0];
				REG_RANGE_LO:       range_lo_q       <= pwdata[DEPTH_W-1:0];
				REG_RANGE_MAX:      range_max_q      <= pwdata[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DEPTH_ENCODING: prdata = DATA_W'(depth_encoding_q);
			REG_PIXEL_STRIDE:   prdata = DATA_W'(pixel_stride_q);
			REG_CENTER_X:       prdata = DATA_W'(center_x_q);
			REG_CENTER_Y:       prdata = DATA_W'(center_y_q);
			REG_INV_FOCAL_X:    prdata = DATA_W'(inv_focal_x_q);
			REG_INV_FOCAL_Y:    prdata = DATA_W'(inv_focal_y_q);
			REG_RANGE_LO:       prdata = DATA_W'(range_lo_q);
			REG_RANGE_MAX:      prdata = DATA_W'(range_max_q);
			default:            prdata = '0;
		endcase
	end

	always_comb begin
		fcfg.depth_encoding = depth_encoding_q;
		fcfg.pixel_stride   = pixel_stride_q;
		fcfg.range_lo       = range_lo_q;
		fcfg.range_max      = range_max_q;
		bcfg.center_x       = center_x_q;
		bcfg.center_y       = center_y_q;
		bcfg.inv_focal_x    = inv_focal_x_q;
		bcfg.inv_focal_y    = inv_focal_y_q;
	end

	dpb_front #(
		.MAX_DIMENSION (MAX_DIMENSION),
		.MAX_STRIDE    (MAX_STRIDE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (fcfg),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.depth_word  (depth_word),
		.frame_first (frame_first),
		.row_last    (row_last),
		.q_count     (q_count),
		.push        (push),
		.push_col    (push_col),
		.push_row    (push_row),
		.push_z      (push_z)
	);

	assign push_data = {push_col, push_row, push_z};

	dpb_queue #(.DATA_W(QD_W)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data),
		.count      (q_count)
	);

	dpb_back #(.MAX_DIMENSION(MAX_DIMENSION)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (bcfg),
		.head_valid  (head_valid),
		.head_col    (head_data[QD_W-1 -: CNT_W]),
		.head_row    (head_data[DEPTH_W +: CNT_W]),
		.head_z      (head_data[DEPTH_W-1:0]),
		.pop         (pop),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z)
	);

endmodule

`default_nettype wire

[design/dpb_checker.sv]
`default_nettype none

module dpb_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dpb_pkg::ADDR_W-1:0]         paddr,
	input  logic [dpb_pkg::DATA_W-1:0]         pwdata,
	input  logic [dpb_pkg::DATA_W-1:0]         prdata,
	input  logic                               pready,
	input  logic                               point_valid,
	input  logic                               point_stall,
	input  logic signed [dpb_pkg::COORD_W-1:0] point_x,
	input  logic signed [dpb_pkg::COORD_W-1:0] point_y,
	input  logic [dpb_pkg::DEPTH_W-1:0]        point_z
);
	import dpb_pkg::*;

	logic [DEPTH_W-1:0] range_lo_q, range_max_q;
	logic [INV_W-1:0]   inv_x_q, inv_y_q;
	reg_idx_t           reg_idx;

	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	// shadow copies of the registers the checks depend on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_lo_q  <= '0;
			range_max_q <= '1;
			inv_x_q     <= '0;
			inv_y_q     <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_INV_FOCAL_X: inv_x_q     <= pwdata[INV_W-1:0];
				REG_INV_FOCAL_Y: inv_y_q     <= pwdata[INV_W-1:0];
				REG_RANGE_LO:    range_lo_q  <= pwdata[DEPTH_W-1:0];
				REG_RANGE_MAX:   range_max_q <= pwdata[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	a_point_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_stall |=> point_valid && $stable(point_x)
			&& $stable(point_y) && $stable(point_z))
		else $error("stalled point transaction changed");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> point_z != '0 && point_z >= range_lo_q && point_z <= range_max_q)
		else $error("point depth zero or outside range limits");

	a_zero_inv: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid |-> (inv_x_q != '0 || point_x == '0) && (inv_y_q != '0 || point_y == '0))
		else $error("nonzero coordinate with zero inverse focal length");

	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && reg_idx == REG_RANGE_MAX |-> prdata == DATA_W'(range_max_q))
		else $error("range_max readback mismatch");

endmodule

bind depth_pixel_backprojection dpb_checker u_checker (.*);

`default_nettype wire
